FILE: hdl/priority_task_queue_with_cancel_unit_assert.svh
// Assertion macros for the priority task queue
`ifndef PRIORITY_TASK_QUEUE_WITH_CANCEL_UNIT_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_WITH_CANCEL_UNIT_ASSERT_SVH
// implication that must hold every cycle out of reset
`define PTQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define PTQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hdl/ptq_pkg.sv
// ------------------------------------------------------------------
// ptq_pkg
// Types and constants shared by the priority task queue.
// ------------------------------------------------------------------
package ptq_pkg;
	localparam int QueueDepthDef = 16;
	localparam int PrioLevelsDef = 4;
	localparam int IdBitsDef     = 16;

	localparam logic [2:0] OP_SCHED      = 3'd0;
	localparam logic [2:0] OP_CANCEL     = 3'd1;
	localparam logic [2:0] OP_CANCEL_ALL = 3'd2;
	localparam logic [2:0] OP_QUERY      = 3'd3;
	localparam logic [2:0] OP_DISPATCH   = 3'd4;

	localparam logic [2:0] ST_PENDING   = 3'd0;
	localparam logic [2:0] ST_RUNNING   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NONE      = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;
endpackage

FILE: hdl/ptq_ram.sv
// ------------------------------------------------------------------
// ptq_ram
// Simple dual-port RAM, one write and one registered read port.
// ------------------------------------------------------------------
module ptq_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/priority_task_queue_with_cancel_unit.sv
// ------------------------------------------------------------------
// priority_task_queue_with_cancel_unit
// Stable priority queue of tasks with cancel, held in one RAM.
// ------------------------------------------------------------------
// Input channel: in_valid/in_ready carry operation, priority_req,
// cancelable and task_id. Output channel: out_valid/out_ready carry
// result_id, ok, status and last. Config: cfg_we/cfg_wdata writes
// dispatch_hold.
// One item is handled at a time; in_ready is high only while idle.
// The controller walks the entry RAM one entry per cycle, except that a
// cancel-all holds while a found entry waits for the output register.
// Schedule scans to its insert point and shifts the tail up; cancel
// and dispatch shift the tail down over the removed entry; a query
// stops at its match. A full queue, a held or empty dispatch and an
// unknown code give their result without a walk. The next item is taken
// in the cycle after the final result of an item enters the output register.
// Results wait in a single output register; while the receiver stalls
// the walk holds at its next result and no new item is taken.
// Reset empties the queue, zeroes the id counter and clears the hold;
// RAM contents are not cleared and are only read below the count.
// ------------------------------------------------------------------
module priority_task_queue_with_cancel_unit
	import ptq_pkg::*;
#(
	parameter int QueueDepth = QueueDepthDef,
	parameter int PrioLevels = PrioLevelsDef,
	parameter int IdBits     = IdBitsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        operation,
	input  logic [1:0]        priority_req,
	input  logic              cancelable,
	input  logic [IdBits-1:0] task_id,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IdBits-1:0] result_id,
	output logic              ok,
	output logic [2:0]        status,
	output logic              last,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	`include "priority_task_queue_with_cancel_unit_assert.svh"

	localparam int AW = $clog2(QueueDepth);
	localparam int CW = $clog2(QueueDepth + 1);
	localparam int PW = (PrioLevels > 1) ? $clog2(PrioLevels) : 1;
	localparam int EW = IdBits + PW + 1;

	state_t state_q, state_d;
	logic              hold_q;
	logic [CW-1:0]     count_q, count_d;
	logic [IdBits-1:0] next_id_q;
	logic [2:0]        op_q;
	logic [PW-1:0]     prio_q;
	logic              can_q;
	logic [IdBits-1:0] tid_q;
	logic [CW-1:0]     idx_q, idx_d;
	logic [EW-1:0]     carry_q;
	logic              pend_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [EW-1:0]     wdata, rdata;
	logic [IdBits-1:0] r_id;
	logic [PW-1:0]     r_prio;
	logic              r_can;
	logic [PW-1:0]     prio_sat;
	logic              obuf_free;
	logic              at_end;
	logic              emit;
	logic              done;
	logic [IdBits-1:0] e_id;
	logic              e_ok, e_last;
	logic [2:0]        e_st;
	logic              take_carry;
	logic              load_new;
	logic              set_pend;
	logic              to_shift;
	logic              bump_id;

	assign r_id   = rdata[EW-1 -: IdBits];
	assign r_prio = rdata[1 +: PW];
	assign r_can  = rdata[0];

	always_comb begin
		if (32'(priority_req) >= 32'(PrioLevels)) begin
			prio_sat = PW'(PrioLevels - 1);
		end else begin
			prio_sat = PW'(priority_req);
		end
	end

	ptq_ram #(.Width(EW), .Depth(QueueDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// rdata always holds entry idx_q: read the next index
	assign obuf_free = !out_valid || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign at_end    = (idx_q >= count_q);
	assign raddr     = AW'(idx_d);
	assign done      = emit && obuf_free && e_last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_SCAN;
			S_SCAN: begin
				if (done) state_d = S_IDLE;
				else if (to_shift) state_d = S_SHIFT;
			end
			S_SHIFT: if (done) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// result selection, walk and write control
	always_comb begin
		emit = 1'b0; e_id = '0; e_ok = 1'b0; e_st = ST_NONE; e_last = 1'b1;
		we = 1'b0; waddr = AW'(idx_q); wdata = carry_q;
		idx_d = idx_q; count_d = count_q;
		take_carry = 1'b0; load_new = 1'b0; set_pend = 1'b0;
		to_shift = 1'b0; bump_id = 1'b0;
		case (state_q)
			S_IDLE: idx_d = '0;
			S_SCAN: begin
				case (op_q)
					OP_SCHED: begin
						if (count_q >= CW'(QueueDepth)) begin
							emit = 1'b1; e_st = ST_FULL;
						end else if (at_end || r_prio > prio_q) begin
							load_new = 1'b1; to_shift = 1'b1;
						end else begin
							idx_d = idx_q + CW'(1);
						end
					end
					OP_CANCEL: begin
						if (at_end) begin
							emit = 1'b1; e_id = tid_q; e_st = ST_CANCELLED;
						end else if (r_id == tid_q && r_can) begin
							to_shift = 1'b1; idx_d = idx_q + CW'(1);
						end else begin
							idx_d = idx_q + CW'(1);
						end
					end
					OP_QUERY: begin
						if (at_end) begin
							emit = 1'b1; e_id = tid_q; e_st = ST_CANCELLED;
						end else if (r_id == tid_q) begin
							emit = 1'b1; e_id = tid_q; e_ok = 1'b1; e_st = ST_PENDING;
						end else begin
							idx_d = idx_q + CW'(1);
						end
					end
					OP_CANCEL_ALL: begin
						// hold one found entry back so the final one carries last
						if (at_end) begin
							emit = 1'b1;
							if (pend_q) begin
								e_id = carry_q[EW-1 -: IdBits]; e_ok = 1'b1;
								e_st = ST_CANCELLED;
							end
							if (obuf_free) count_d = '0;
						end else if (r_can) begin
							if (pend_q) begin
								emit = 1'b1; e_id = carry_q[EW-1 -: IdBits]; e_ok = 1'b1;
								e_st = ST_CANCELLED; e_last = 1'b0;
							end
							if (!pend_q || obuf_free) begin
								take_carry = 1'b1; set_pend = 1'b1;
								idx_d = idx_q + CW'(1);
							end
						end else begin
							idx_d = idx_q + CW'(1);
						end
					end
					OP_DISPATCH: begin
						if (hold_q || count_q == '0) begin
							emit = 1'b1;
						end else begin
							take_carry = 1'b1; to_shift = 1'b1; idx_d = idx_q + CW'(1);
						end
					end
					default: emit = 1'b1;
				endcase
			end
			S_SHIFT: begin
				if (op_q == OP_SCHED) begin
					// write carry at idx, carry <- old entry
					if (!at_end) begin
						we = 1'b1; take_carry = 1'b1; idx_d = idx_q + CW'(1);
					end else begin
						emit = 1'b1; e_id = next_id_q; e_ok = 1'b1; e_st = ST_PENDING;
						we = obuf_free; bump_id = obuf_free;
						if (obuf_free) count_d = count_q + CW'(1);
					end
				end else begin
					// removal: entry[idx-1] <- entry[idx]
					if (!at_end) begin
						we = 1'b1; waddr = AW'(idx_q - CW'(1)); wdata = rdata;
						idx_d = idx_q + CW'(1);
					end else begin
						emit = 1'b1; e_ok = 1'b1;
						if (op_q == OP_DISPATCH) begin
							e_id = carry_q[EW-1 -: IdBits]; e_st = ST_RUNNING;
						end else begin
							e_id = tid_q; e_st = ST_CANCELLED;
						end
						if (obuf_free) count_d = count_q - CW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; hold_q <= 1'b0; count_q <= '0; next_id_q <= '0;
			out_valid <= 1'b0; idx_q <= '0; pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			count_q <= count_d;
			if (cfg_we) hold_q <= cfg_wdata;
			if (emit && obuf_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (state_q == S_IDLE) pend_q <= 1'b0;
			else if (set_pend) pend_q <= 1'b1;
			if (bump_id) next_id_q <= next_id_q + IdBits'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= operation; prio_q <= prio_sat; can_q <= cancelable; tid_q <= task_id;
		end
		if (load_new) carry_q <= {next_id_q, prio_q, can_q};
		else if (take_carry) carry_q <= rdata;
		if (emit && obuf_free) begin
			result_id <= e_id; ok <= e_ok; status <= e_st; last <= e_last;
		end
	end

	`PTQ_ASSERT_IMP(a_count_max, 1'b1, count_q <= CW'(QueueDepth))
	`PTQ_ASSERT_IMP(a_busy_no_ready, state_q != S_IDLE, !in_ready)
	`PTQ_ASSERT_IMP(a_write_in_range, we, waddr < AW'(QueueDepth - 1) || waddr == AW'(QueueDepth - 1))
	`PTQ_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(result_id))
endmodule
